>>> hdl/exact_color_palette_builder_unit_macros.svh
// ----------------------------------------------------------------------------
// exact_color_palette_builder_unit_macros
// Assertion macros for the palette builder RTL.
// ----------------------------------------------------------------------------
`ifndef EXACT_COLOR_PALETTE_BUILDER_UNIT_MACROS_SVH
`define EXACT_COLOR_PALETTE_BUILDER_UNIT_MACROS_SVH

// property checked every clock, idle during reset
`define ECPB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ECPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ecpb_pkg.sv
// ----------------------------------------------------------------------------
// ecpb_pkg
// Sizes and the token word that travels along the palette cell row.
// ----------------------------------------------------------------------------
package ecpb_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
    localparam int COLOR_W         = 32;
    localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [CNT_W-1:0]   count;
        logic               ovf;
        logic               done;
        logic               fresh;
        logic [IDX_W-1:0]   idx;
    } tok_t;

endpackage

>>> hdl/exact_color_palette_builder_unit.sv
// ----------------------------------------------------------------------------
// exact_color_palette_builder_unit
// Exact-match RGBA palette builder over a row of PALETTE_ENTRIES cells.
// A new pixel is accepted only once the last one has left the row and has
// been placed in the output register; the pixel token walks the whole cell
// row, one cell a cycle, and the next pixel needs its count.
// Reset: palette empty, overflow clear, has_alpha = 1; no clearing pass.
// ----------------------------------------------------------------------------
`include "exact_color_palette_builder_unit_macros.svh"

module exact_color_palette_builder_unit
    import ecpb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] alpha,
    input  logic       frame_start,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] color_index,
    output logic       is_new,
    output logic       overflow,
    output logic [8:0] palette_count
);

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             fresh;
        logic             ovf;
        logic [CNT_W-1:0] count;
    } res_t;

    logic             has_alpha_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             overflow_reg, overflow_next;
    logic             busy_reg, busy_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;
    res_t             pend_reg;
    res_t             out_reg;

    logic             chain_valid [PALETTE_ENTRIES+1];
    tok_t             chain_tok   [PALETTE_ENTRIES+1];
    logic [PALETTE_ENTRIES-1:0] cell_busy;

    logic             accept;
    logic             slot_free;
    logic             tail_valid;
    tok_t             tail_tok;
    res_t             tail_res;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        chain_valid[0]       = accept;
        chain_tok[0].color   = {red, green, blue, has_alpha_reg ? alpha : OPAQUE_ALPHA};
        chain_tok[0].count   = frame_start ? '0 : count_reg;
        chain_tok[0].ovf     = frame_start ? 1'b0 : overflow_reg;
        chain_tok[0].done    = 1'b0;
        chain_tok[0].fresh   = 1'b0;
        chain_tok[0].idx     = '0;
    end

    for (genvar i = 0; i < PALETTE_ENTRIES; i++)
    begin : g_cell
        ecpb_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cell_idx      (IDX_W'(i)),
            .tok_in_valid  (chain_valid[i]),
            .tok_in        (chain_tok[i]),
            .tok_out_valid (chain_valid[i+1]),
            .tok_out       (chain_tok[i+1])
        );
        assign cell_busy[i] = chain_valid[i+1];
    end

    assign tail_valid = chain_valid[PALETTE_ENTRIES];
    assign tail_tok   = chain_tok[PALETTE_ENTRIES];

    always_comb
    begin
        tail_res.idx   = tail_tok.done ? tail_tok.idx : '0;
        tail_res.fresh = tail_tok.fresh;
        tail_res.ovf   = tail_tok.ovf || !tail_tok.done;
        tail_res.count = tail_tok.count;
    end

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        busy_next       = busy_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (accept)
        begin
            busy_next = 1'b1;
        end

        if (tail_valid)
        begin
            count_next    = tail_res.count;
            overflow_next = tail_res.ovf;
            if (slot_free)
            begin
                out_valid_next = 1'b1;
                busy_next      = 1'b0;
            end
            else
            begin
                pend_valid_next = 1'b1;
            end
        end
        else if (pend_valid_reg && slot_free)
        begin
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_alpha_reg  <= 1'b1;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                has_alpha_reg <= cfg_data;
            end
            count_reg      <= count_next;
            overflow_reg   <= overflow_next;
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_valid && !slot_free)
        begin
            pend_reg <= tail_res;
        end
        if (tail_valid && slot_free)
        begin
            out_reg <= tail_res;
        end
        else if (pend_valid_reg && slot_free)
        begin
            out_reg <= pend_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign color_index   = 8'(out_reg.idx);
    assign is_new        = out_reg.fresh;
    assign overflow      = out_reg.ovf;
    assign palette_count = 9'(out_reg.count);

    `ECPB_ASSERT(a_one_token, $onehot0(cell_busy), "more than one pixel in the cell row")
    `ECPB_ASSERT(a_tail_busy, !tail_valid || busy_reg, "token left the row while idle")
    `ECPB_ASSERT(a_pend_full, !pend_valid_reg || out_valid_reg, "pending word with empty output")
    `ECPB_ASSERT(a_count_max, count_reg <= CNT_W'(PALETTE_ENTRIES), "palette count past capacity")
    `ECPB_ASSERT_NEXT(a_accept_busy, accept, busy_reg, "accepted pixel did not mark busy")

endmodule

>>> hdl/ecpb_cell.sv
// ----------------------------------------------------------------------------
// ecpb_cell
// One palette entry: compares the passing pixel, claims the entry when it is
// the first free one, and hands the token to the next cell.
// ----------------------------------------------------------------------------
module ecpb_cell
    import ecpb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  logic             tok_in_valid,
    input  tok_t             tok_in,
    output logic             tok_out_valid,
    output tok_t             tok_out
);

    logic [COLOR_W-1:0] entry_reg;
    logic               valid_reg;
    tok_t               tok_reg;
    tok_t               tok_next;
    logic               in_use;
    logic               hit;
    logic               claim;

    always_comb
    begin
        in_use = CNT_W'(cell_idx) < tok_in.count;
        hit    = tok_in_valid && !tok_in.done && in_use && (entry_reg == tok_in.color);
        claim  = tok_in_valid && !tok_in.done && (CNT_W'(cell_idx) == tok_in.count);

        tok_next = tok_in;
        if (hit)
        begin
            tok_next.done = 1'b1;
            tok_next.idx  = cell_idx;
        end
        else if (claim)
        begin
            tok_next.done  = 1'b1;
            tok_next.fresh = 1'b1;
            tok_next.idx   = cell_idx;
            tok_next.count = tok_in.count + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (claim)
        begin
            entry_reg <= tok_in.color;
        end
    end

    assign tok_out_valid = valid_reg;
    assign tok_out       = tok_reg;

endmodule
